// File: design/ili_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ili_pkg
// Shared types and constants for the indexed list block.
// ----------------------------------------------------------------------------
package ili_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = 7;
  localparam int POS_W    = 7;
  localparam int VAL_W    = 32;
  localparam int OP_W     = 3;
  localparam int ST_W     = 2;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 48;

  typedef logic [OP_W-1:0] opcode_t;
  typedef logic [ST_W-1:0] status_t;

  localparam opcode_t OP_READ = 3'd0;
  localparam opcode_t OP_HEAD = 3'd1;
  localparam opcode_t OP_TAIL = 3'd2;
  localparam opcode_t OP_AT   = 3'd3;
  localparam opcode_t OP_DEL  = 3'd4;

  localparam status_t ST_DONE  = 2'd0;
  localparam status_t ST_RANGE = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

endpackage
`default_nettype wire

// File: design/indexed_list_insert_delete.sv
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_list_insert_delete
// Ordered list of up to 64 signed 32-bit values held in one RAM.
// ----------------------------------------------------------------------------
// One transaction in, one transaction out. A read that hits passes through S_RD
// (one RAM read) before S_FIN; a rejected operation, an append or a delete of
// the last entry goes straight to S_FIN. An insert before position p walks S_UP
// from the last entry down to p, then writes the value in S_PUT; a delete at p walks
// S_DN from p+1 up to the last entry: the single RAM write port moves one entry per
// cycle, with the next read issued alongside each write. A finished result sits in
// the output register, and the next transaction is taken once it has been handed over.
// ----------------------------------------------------------------------------
module indexed_list_insert_delete (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [2:0] opcode, [9:3] position, [41:10] item_value, [47:42] zero
  input  wire logic [47:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [31:0] read_value, [33:32] status, [40:34] entry_count, [47:41] zero
  output logic [47:0]      out_tdata
);
  import ili_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_UP   = 3'd2;
  localparam logic [2:0] S_PUT  = 3'd3;
  localparam logic [2:0] S_DN   = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [ADDR_W-1:0] cur_r, cur_nxt;
  logic [ADDR_W-1:0] pos_r, pos_nxt;
  logic [VAL_W-1:0]  val_r, val_nxt;
  logic [VAL_W-1:0]  res_val_r, res_val_nxt;
  status_t           res_st_r, res_st_nxt;
  logic              out_valid_r;
  logic [VAL_W-1:0]  out_val_r;
  status_t           out_st_r;
  logic [CNT_W-1:0]  out_cnt_r;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [VAL_W-1:0]  ram_wdata, ram_rdata;

  opcode_t           in_op;
  logic [POS_W-1:0]  in_pos;
  logic [VAL_W-1:0]  in_val;
  logic [CNT_W-1:0]  ins_pos;
  logic              full;
  logic              accept;
  logic              out_free;
  logic [CNT_W-1:0]  last_idx;

  assign in_op    = opcode_t'(in_tdata[2:0]);
  assign in_pos   = in_tdata[9:3];
  assign in_val   = in_tdata[41:10];
  assign full     = (count_r == CNT_W'(CAPACITY));
  assign in_tready = (state_r == S_IDLE);
  assign accept   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign last_idx = count_r - CNT_W'(1);

  ili_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    cur_nxt     = cur_r;
    pos_nxt     = pos_r;
    val_nxt     = val_r;
    res_val_nxt = res_val_r;
    res_st_nxt  = res_st_r;
    ram_we      = 1'b0;
    ram_waddr   = cur_r;
    ram_wdata   = ram_rdata;
    ram_raddr   = cur_r;
    ins_pos     = in_pos;
    unique case (in_op)
      OP_HEAD: ins_pos = '0;
      OP_TAIL: ins_pos = count_r;
      default: ins_pos = in_pos;
    endcase

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_val_nxt = '0;
          res_st_nxt  = ST_DONE;
          val_nxt     = in_val;
          pos_nxt     = ins_pos[ADDR_W-1:0];
          state_nxt   = S_FIN;
          priority case (1'b1)
            (in_op == OP_READ): begin
              if (in_pos < count_r) begin
                ram_raddr = in_pos[ADDR_W-1:0];
                state_nxt = S_RD;
              end else begin
                res_val_nxt = '1;
                res_st_nxt  = ST_RANGE;
              end
            end
            (in_op == OP_HEAD || in_op == OP_TAIL || in_op == OP_AT): begin
              if (ins_pos > count_r) begin
                res_st_nxt = ST_RANGE;
              end else if (full) begin
                res_st_nxt = ST_FULL;
              end else if (ins_pos == count_r) begin
                // append: no entry moves
                ram_we    = 1'b1;
                ram_waddr = ins_pos[ADDR_W-1:0];
                ram_wdata = in_val;
                count_nxt = count_r + CNT_W'(1);
              end else begin
                cur_nxt   = last_idx[ADDR_W-1:0];
                ram_raddr = last_idx[ADDR_W-1:0];
                state_nxt = S_UP;
              end
            end
            (in_op == OP_DEL): begin
              if (in_pos >= count_r) begin
                res_st_nxt = ST_RANGE;
              end else if (in_pos == last_idx) begin
                count_nxt = last_idx;
              end else begin
                cur_nxt   = in_pos[ADDR_W-1:0] + ADDR_W'(1);
                ram_raddr = in_pos[ADDR_W-1:0] + ADDR_W'(1);
                state_nxt = S_DN;
              end
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        res_val_nxt = ram_rdata;
        state_nxt   = S_FIN;
      end
      S_UP: begin
        // move entry cur up one place, then fetch the one below it
        ram_we    = 1'b1;
        ram_waddr = cur_r + ADDR_W'(1);
        if (cur_r == pos_r) begin
          state_nxt = S_PUT;
        end else begin
          cur_nxt   = cur_r - ADDR_W'(1);
          ram_raddr = cur_r - ADDR_W'(1);
        end
      end
      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r;
        ram_wdata = val_r;
        count_nxt = count_r + CNT_W'(1);
        state_nxt = S_FIN;
      end
      S_DN: begin
        // move entry cur down one place, then fetch the next one
        ram_we    = 1'b1;
        ram_waddr = cur_r - ADDR_W'(1);
        if (CNT_W'(cur_r) == last_idx) begin
          count_nxt = last_idx;
          state_nxt = S_FIN;
        end else begin
          cur_nxt   = cur_r + ADDR_W'(1);
          ram_raddr = cur_r + ADDR_W'(1);
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload: hold the result until the output register is free
  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    pos_r     <= pos_nxt;
    val_r     <= val_nxt;
    res_val_r <= res_val_nxt;
    res_st_r  <= res_st_nxt;
    if (state_r == S_FIN && out_free) begin
      out_val_r <= res_val_r;
      out_st_r  <= res_st_r;
      out_cnt_r <= count_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_cnt_r, out_st_r, out_val_r};

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    ##1 (count_r == $past(count_r) || count_r == $past(count_r) + CNT_W'(1)
         || count_r == $past(count_r) - CNT_W'(1)))
    else $error("entry count moved by more than one");

  a_put_fin: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PUT |=> state_r == S_FIN)
    else $error("insert did not finish after placing the value");

  a_load_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_free) |=> out_valid_r && state_r == S_IDLE)
    else $error("result not handed to the output register");

endmodule
`default_nettype wire

// File: design/ili_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ili_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ili_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: bench/ili_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ili_checker
// Watches both stream channels of the indexed list, models the list and
// compares every result transaction with the predicted one.
// ----------------------------------------------------------------------------
module ili_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [47:0] in_tdata,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [47:0] out_tdata,
  output int               fail_count,
  output int               pending_results,
  output int               live_count
);
  import ili_pkg::*;

  typedef struct packed {
    logic [VAL_W-1:0] read_value;
    status_t          status;
    logic [CNT_W-1:0] entry_count;
  } list_result_t;

  logic [VAL_W-1:0] list_vals [CAPACITY];
  int               list_len;
  list_result_t     result_queue [$];

  assign pending_results = result_queue.size();
  assign live_count      = list_len;

  function automatic list_result_t apply_list_op(logic [47:0] word);
    opcode_t          op;
    int               pos;
    logic [VAL_W-1:0] val;
    list_result_t     r;
    int               at;
    bit               full;
    op   = word[2:0];
    pos  = int'(word[9:3]);
    val  = word[41:10];
    full = list_len >= CAPACITY;
    r    = '0;
    r.status = ST_DONE;
    at = -1;
    case (op)
      OP_READ: begin
        if (pos < list_len) r.read_value = list_vals[pos];
        else begin
          r.read_value = '1;
          r.status     = ST_RANGE;
        end
      end
      OP_HEAD: if (full) r.status = ST_FULL; else at = 0;
      OP_TAIL: if (full) r.status = ST_FULL; else at = list_len;
      OP_AT: begin
        if (pos > list_len) r.status = ST_RANGE;
        else if (full) r.status = ST_FULL;
        else at = pos;
      end
      OP_DEL: begin
        if (pos < list_len) begin
          for (int i = pos; i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
          list_len--;
        end else r.status = ST_RANGE;
      end
      default: ;
    endcase
    if (at >= 0) begin
      for (int i = list_len; i > at; i--) list_vals[i] = list_vals[i-1];
      list_vals[at] = val;
      list_len++;
    end
    r.entry_count = CNT_W'(list_len);
    return r;
  endfunction

  always @(posedge clk) begin
    list_result_t exp_r;
    list_result_t got;
    int           errs;
    errs = 0;
    if (!rst_n) begin
      list_len   = 0;
      fail_count <= 0;
      result_queue.delete();
    end else begin
      if (in_tvalid && in_tready) result_queue.push_back(apply_list_op(in_tdata));
      if (out_tvalid && out_tready) begin
        got = {out_tdata[31:0], out_tdata[33:32], out_tdata[40:34]};
        if (result_queue.size() == 0) begin
          $error("result with nothing expected: %h", out_tdata);
          errs++;
        end else begin
          exp_r = result_queue.pop_front();
          if (got.read_value !== exp_r.read_value) begin
            $error("read_value expected %0d got %0d", $signed(exp_r.read_value),
                   $signed(got.read_value));
            errs++;
          end
          if (got.status !== exp_r.status) begin
            $error("status expected %0d got %0d", exp_r.status, got.status);
            errs++;
          end
          if (got.entry_count !== exp_r.entry_count) begin
            $error("entry_count expected %0d got %0d", exp_r.entry_count,
                   got.entry_count);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
    end
  end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the indexed list: directed corner operations, then
// random list traffic with idling on both channels and a long output stall.
// ----------------------------------------------------------------------------
module tb_top;
  import ili_pkg::*;

  localparam int RANDOM_OPS  = 1800;
  localparam int QUIET_AFTER = 1500;    // no idling past this transaction
  localparam int STALL_LIMIT = 20000;   // cycles without any transaction

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  // [2:0] opcode, [9:3] position, [41:10] item_value, [47:42] zero
  logic [47:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  // [31:0] read_value, [33:32] status, [40:34] entry_count, [47:41] zero
  logic [47:0] out_tdata;

  int  fail_count, pending_results, live_count;
  int  sent_ops = 0;
  bit  hold_drain = 0;       // receiver held off for a long stretch
  int  quiet_cycles = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  indexed_list_insert_delete i_dut (.*);

  ili_checker i_chk (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .out_tvalid, .out_tready,
    .out_tdata, .fail_count, .pending_results, .live_count
  );

  // Send one transaction; hold it until accepted.
  task automatic send_op(opcode_t op, int pos, logic [31:0] val);
    in_tvalid <= 1;
    in_tdata  <= {6'd0, val, pos[6:0], op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_ops++;
  endtask

  // Drop valid for a random burst, only in the busy part of the run.
  task automatic maybe_idle();
    int gap;
    if (sent_ops < QUIET_AFTER && $urandom_range(3) == 0) begin
      gap = $urandom_range(11, 1);
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] any_value();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // Receiver: random stalls, plus one long hold-off while the sender runs on.
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      if (hold_drain) begin
        out_tready <= 0;
        repeat (400) @(posedge clk);
        hold_drain = 0;
      end else if (sent_ops < QUIET_AFTER && $urandom_range(3) == 0) begin
        gap = $urandom_range(11, 1);
        out_tready <= 0;
        repeat (gap) @(posedge clk);
      end else begin
        out_tready <= 1;
        @(posedge clk);
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (rst_n && quiet_cycles > STALL_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin
    int          pos, r, n;
    opcode_t     op;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: empty-list corners, every opcode, full store, extremes.
    send_op(OP_READ, 0, '0);
    send_op(OP_DEL, 0, '0);
    send_op(OP_AT, 1, 32'h1);
    send_op(OP_AT, 0, 32'h8000_0000);
    send_op(OP_HEAD, 0, 32'h7FFF_FFFF);
    send_op(OP_TAIL, 127, 32'hFFFF_FFFF);
    send_op(OP_AT, 3, 32'h5555_5555);
    send_op(OP_AT, 1, 32'hAAAA_AAAA);
    send_op(OP_READ, 0, '0);
    send_op(OP_READ, 4, '0);
    send_op(OP_READ, 5, '0);
    send_op(OP_READ, 127, '0);
    send_op(OP_DEL, 4, '0);
    send_op(OP_DEL, 0, '0);
    send_op(OP_DEL, 1, '0);
    send_op(3'd5, 0, '1);
    send_op(3'd6, 127, '1);
    send_op(3'd7, 64, '1);
    // Fill to capacity with a long output stall so the input backs up.
    hold_drain = 1;
    while (live_count < CAPACITY) send_op(OP_TAIL, 0, $urandom());
    send_op(OP_HEAD, 0, '1);
    send_op(OP_TAIL, 0, '1);
    send_op(OP_AT, 64, '1);
    send_op(OP_AT, 65, '1);
    send_op(OP_READ, 63, '0);
    send_op(OP_READ, 64, '0);
    send_op(OP_DEL, 63, '0);
    // Pause until every expected result has come.
    in_tvalid <= 0;
    while (pending_results != 0) @(posedge clk);

    // Random: mostly in-range work, occasional out-of-range and unused codes.
    for (int k = 0; k < RANDOM_OPS; k++) begin
      maybe_idle();
      n = live_count + pending_results * 0;
      r = $urandom_range(99);
      if (r < 4) op = opcode_t'($urandom_range(7, 5));
      else if (r < 22) op = OP_READ;
      else if (r < 34) op = OP_HEAD;
      else if (r < 46) op = OP_TAIL;
      else if (r < 64) op = OP_AT;
      else op = OP_DEL;
      // Lean towards deletes when the list is long.
      if (n > 56 && $urandom_range(1)) op = OP_DEL;
      if ($urandom_range(15) == 0) pos = $urandom_range(127);
      else pos = $urandom_range(n > 0 ? n : 1) - (op == OP_AT ? 0 : (n > 0 ? 1 : 0));
      if (pos < 0) pos = 0;
      send_op(op, pos, any_value());
    end
    in_tvalid <= 0;

    while (pending_results != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
